// File: hdl/lrf_pkg.sv
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants for the least-squares line fit with residuals.
// ----------------------------------------------------------------------------
`default_nettype none

package lrf_pkg;

   localparam int MAX_PAIRS   = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_W      = $clog2(MAX_PAIRS);
   localparam int CNT_W       = $clog2(MAX_PAIRS + 1);
   localparam int SUM1_W      = 22;
   localparam int SUM2_W      = 38;
   localparam int MUL_A_W     = 38;
   localparam int MUL_B_W     = 22;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int FIT_W       = 48;
   localparam int DIV_W       = 64;
   localparam int STEP_W      = 7;
   localparam int ROOT_W      = 31;
   localparam int SHF_W       = 6;
   localparam int Q_W         = 32;
   localparam int CORR_W      = 16;
   localparam int IDX_W       = 5;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_value;
      logic signed [SAMPLE_BITS-1:0] y_value;
      logic                          last_pair;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         point_index;
      logic signed [Q_W-1:0]    predicted_y;
      logic signed [Q_W-1:0]    residual;
      logic signed [Q_W-1:0]    slope;
      logic signed [Q_W-1:0]    mean_x;
      logic signed [Q_W-1:0]    mean_y;
      logic signed [CORR_W-1:0] correlation;
      logic                     degenerate;
      logic                     last_result;
   } rsp_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] x_value;
      logic signed [SAMPLE_BITS-1:0] y_value;
   } pair_type;

   typedef struct packed {
      logic [DIV_W-1:0]  num;
      logic [DIV_W-1:0]  den;
      logic [DIV_W-1:0]  init_rem;
      logic [STEP_W-1:0] steps;
      logic              clamp;
   } div_req_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_NORM,
      SQ_ROOT
   } sq_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MAC_XX,
      ST_MAC_YY,
      ST_MAC_XY,
      ST_MAC_END,
      ST_F_C1,
      ST_F_C2,
      ST_F_DX1,
      ST_F_DX2,
      ST_F_DY1,
      ST_F_DY2,
      ST_F_DY3,
      ST_DIV_MX,
      ST_WAIT_MX,
      ST_DIV_MY,
      ST_WAIT_MY,
      ST_DIV_SL,
      ST_WAIT_SL,
      ST_SQ_X,
      ST_WAIT_SQX,
      ST_SQ_Y,
      ST_WAIT_SQY,
      ST_MUL_P,
      ST_DIV_R,
      ST_WAIT_R,
      ST_O_ADDR,
      ST_O_DIFF,
      ST_O_MUL,
      ST_O_EMIT
   } state_type;

endpackage

`default_nettype wire

// File: hdl/linear_regression_fit_residuals.sv
// ----------------------------------------------------------------------------
// linear_regression_fit_residuals
// Least-squares fit of y on x over stored pairs, then one result per pair.
// ----------------------------------------------------------------------------
// Load: per request, a store write plus three passes of one multiplier.
// Fit: once per set, using the 64-step serial divider (three passes plus one of
// a+b+16 steps) and two serial square roots; when a variance is zero only the
// two mean passes run.
// Results: one per pair (memory read, subtract, multiply, round); the
// receiver cannot stall. Reset clears control, count and sums; memory is not.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_regression_fit_residuals (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  lrf_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lrf_pkg::rsp_type rsp_data
);
   import lrf_pkg::*;

   localparam logic [DIV_W-1:0] HALF_Q31 = DIV_W'(1) << 31;
   localparam logic [DIV_W-1:0] HALF_R   = DIV_W'(1) << 15;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [SUM1_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [SUM2_W-1:0] sum_xx_ff, sum_xx_in, sum_yy_ff, sum_yy_in;
   logic signed [SUM2_W-1:0] sum_xy_ff, sum_xy_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic                     last_ff, last_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [FIT_W-1:0]  c_ff, c_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [Q_W-1:0]    mean_x_ff, mean_x_in, mean_y_ff, mean_y_in;
   logic signed [Q_W-1:0]    slope_ff, slope_in;
   logic signed [CORR_W-1:0] corr_ff, corr_in;
   logic                     degen_ff, degen_in;
   logic [ROOT_W-1:0]        rx_ff, rx_in;
   logic [SHF_W-1:0]         ax_ff, ax_in;
   logic [2*ROOT_W-1:0]      p_ff;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [25:0]       diff_ff, diff_in;
   logic signed [23:0]       yq_ff, yq_in;
   logic signed [57:0]       pp_ff;
   logic                     strobe_ff, strobe_in;
   rsp_type                  rsp_ff, rsp_in;

   logic        accept, full;
   logic        div_start, sq_start, sq_done, div_done;
   div_req_type div_req;
   logic [DIV_W-1:0]  div_q, sq_value, qq;
   logic [ROOT_W-1:0] sq_root;
   logic [SHF_W-1:0]  sq_shift;
   logic              mem_wr;
   pair_type          mem_wdata, mem_rdata;
   logic [FIT_W-1:0]  abs_c;
   logic [SUM1_W-1:0] abs_s;
   logic [57:0]       abs_pp;
   logic [41:0]       rnd;
   logic signed [43:0] pred_sum;
   logic signed [33:0] res_sum;
   logic signed [Q_W-1:0] pred;

   function automatic logic signed [Q_W-1:0] sat44(input logic signed [43:0] v);
      if (!v[43] && (v[42:31] != '0)) begin
         return 32'sh7fff_ffff;
      end else if (v[43] && (v[42:31] != '1)) begin
         return 32'sh8000_0000;
      end
      return v[Q_W-1:0];
   endfunction

   function automatic logic signed [Q_W-1:0] sat34(input logic signed [33:0] v);
      if (!v[33] && (v[32:31] != '0)) begin
         return 32'sh7fff_ffff;
      end else if (v[33] && (v[32:31] != '1)) begin
         return 32'sh8000_0000;
      end
      return v[Q_W-1:0];
   endfunction

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(MAX_PAIRS));
   assign abs_c  = c_ff[FIT_W-1] ? FIT_W'(-c_ff) : FIT_W'(c_ff);

   assign mem_wr    = accept && !full;
   assign mem_wdata = '{x_value: req_data.x_value, y_value: req_data.y_value};

   lrf_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (mem_wdata),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   lrf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   lrf_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_value),
      .done  (sq_done),
      .root  (sq_root),
      .shift (sq_shift)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MAC_XX: begin
            mul_a = {{(MUL_A_W-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
            mul_b = {{(MUL_B_W-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
         end
         ST_MAC_YY: begin
            mul_a = {{(MUL_A_W-SAMPLE_BITS){y_ff[SAMPLE_BITS-1]}}, y_ff};
            mul_b = {{(MUL_B_W-SAMPLE_BITS){y_ff[SAMPLE_BITS-1]}}, y_ff};
         end
         ST_MAC_XY: begin
            mul_a = {{(MUL_A_W-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
            mul_b = {{(MUL_B_W-SAMPLE_BITS){y_ff[SAMPLE_BITS-1]}}, y_ff};
         end
         ST_F_C1: begin
            mul_a = sum_xy_ff;
            mul_b = {{(MUL_B_W-CNT_W){1'b0}}, count_ff};
         end
         ST_F_C2: begin
            mul_a = {{(MUL_A_W-SUM1_W){sum_x_ff[SUM1_W-1]}}, sum_x_ff};
            mul_b = sum_y_ff;
         end
         ST_F_DX1: begin
            mul_a = sum_xx_ff;
            mul_b = {{(MUL_B_W-CNT_W){1'b0}}, count_ff};
         end
         ST_F_DX2: begin
            mul_a = {{(MUL_A_W-SUM1_W){sum_x_ff[SUM1_W-1]}}, sum_x_ff};
            mul_b = sum_x_ff;
         end
         ST_F_DY1: begin
            mul_a = sum_yy_ff;
            mul_b = {{(MUL_B_W-CNT_W){1'b0}}, count_ff};
         end
         ST_F_DY2: begin
            mul_a = {{(MUL_A_W-SUM1_W){sum_y_ff[SUM1_W-1]}}, sum_y_ff};
            mul_b = sum_y_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xx_in = sum_xx_ff;
      sum_yy_in = sum_yy_ff;
      sum_xy_in = sum_xy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      last_in   = last_ff;
      c_in      = c_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      mean_x_in = mean_x_ff;
      mean_y_in = mean_y_ff;
      slope_in  = slope_ff;
      corr_in   = corr_ff;
      degen_in  = degen_ff;
      rx_in     = rx_ff;
      ax_in     = ax_ff;
      idx_in    = idx_ff;
      diff_in   = diff_ff;
      yq_in     = yq_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      div_start = 1'b0;
      div_req   = '0;
      sq_start  = 1'b0;
      sq_value  = '0;
      abs_s     = '0;
      qq        = '0;
      abs_pp    = pp_ff[57] ? 58'(-pp_ff) : 58'(pp_ff);
      rnd       = 42'((abs_pp + 58'd32768) >> 16);
      pred_sum  = {{12{mean_y_ff[Q_W-1]}}, mean_y_ff}
                + (pp_ff[57] ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd}));
      pred      = sat44(pred_sum);
      res_sum   = {{10{yq_ff[23]}}, yq_ff} - {{2{pred[Q_W-1]}}, pred};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in    = req_data.x_value;
               y_in    = req_data.y_value;
               last_in = req_data.last_pair;
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_x_in = sum_x_ff
                           + {{(SUM1_W-SAMPLE_BITS){req_data.x_value[SAMPLE_BITS-1]}},
                              req_data.x_value};
                  sum_y_in = sum_y_ff
                           + {{(SUM1_W-SAMPLE_BITS){req_data.y_value[SAMPLE_BITS-1]}},
                              req_data.y_value};
                  state_in = ST_MAC_XX;
               end else if (req_data.last_pair) begin
                  state_in = ST_F_C1;
               end
            end
         end
         ST_MAC_XX: state_in = ST_MAC_YY;
         ST_MAC_YY: begin
            sum_xx_in = sum_xx_ff + prod_ff[SUM2_W-1:0];
            state_in  = ST_MAC_XY;
         end
         ST_MAC_XY: begin
            sum_yy_in = sum_yy_ff + prod_ff[SUM2_W-1:0];
            state_in  = ST_MAC_END;
         end
         ST_MAC_END: begin
            sum_xy_in = sum_xy_ff + prod_ff[SUM2_W-1:0];
            state_in  = last_ff ? ST_F_C1 : ST_IDLE;
         end
         ST_F_C1: state_in = ST_F_C2;
         ST_F_C2: begin
            c_in     = prod_ff[FIT_W-1:0];
            state_in = ST_F_DX1;
         end
         ST_F_DX1: begin
            c_in     = c_ff - prod_ff[FIT_W-1:0];
            state_in = ST_F_DX2;
         end
         ST_F_DX2: begin
            dx_in    = prod_ff[FIT_W-1:0];
            state_in = ST_F_DY1;
         end
         ST_F_DY1: begin
            dx_in    = dx_ff - prod_ff[FIT_W-1:0];
            state_in = ST_F_DY2;
         end
         ST_F_DY2: begin
            dy_in    = prod_ff[FIT_W-1:0];
            state_in = ST_F_DY3;
         end
         ST_F_DY3: begin
            dy_in    = dy_ff - prod_ff[FIT_W-1:0];
            state_in = ST_DIV_MX;
         end
         ST_DIV_MX: begin
            degen_in  = (dx_ff <= 0) || (dy_ff <= 0);
            slope_in  = '0;
            corr_in   = '0;
            abs_s     = sum_x_ff[SUM1_W-1] ? SUM1_W'(-sum_x_ff) : SUM1_W'(sum_x_ff);
            div_start = 1'b1;
            div_req.num = {{(DIV_W-SUM1_W-9){1'b0}}, abs_s, 9'b0}
                        + {{(DIV_W-CNT_W){1'b0}}, count_ff};
            div_req.den = {{(DIV_W-CNT_W-1){1'b0}}, count_ff, 1'b0};
            div_req.steps = STEP_W'(DIV_W);
            state_in  = ST_WAIT_MX;
         end
         ST_WAIT_MX: begin
            if (div_done) begin
               mean_x_in = sum_x_ff[SUM1_W-1] ? -$signed(div_q[Q_W-1:0])
                                              : $signed(div_q[Q_W-1:0]);
               state_in  = ST_DIV_MY;
            end
         end
         ST_DIV_MY: begin
            abs_s     = sum_y_ff[SUM1_W-1] ? SUM1_W'(-sum_y_ff) : SUM1_W'(sum_y_ff);
            div_start = 1'b1;
            div_req.num = {{(DIV_W-SUM1_W-9){1'b0}}, abs_s, 9'b0}
                        + {{(DIV_W-CNT_W){1'b0}}, count_ff};
            div_req.den = {{(DIV_W-CNT_W-1){1'b0}}, count_ff, 1'b0};
            div_req.steps = STEP_W'(DIV_W);
            state_in  = ST_WAIT_MY;
         end
         ST_WAIT_MY: begin
            if (div_done) begin
               mean_y_in = sum_y_ff[SUM1_W-1] ? -$signed(div_q[Q_W-1:0])
                                              : $signed(div_q[Q_W-1:0]);
               idx_in    = '0;
               state_in  = degen_ff ? ST_O_ADDR : ST_DIV_SL;
            end
         end
         ST_DIV_SL: begin
            div_start   = 1'b1;
            div_req.num = {abs_c[DIV_W-18:0], 17'b0}
                        + {{(DIV_W-FIT_W){1'b0}}, dx_ff};
            div_req.den = {{(DIV_W-FIT_W-1){1'b0}}, dx_ff, 1'b0};
            div_req.steps = STEP_W'(DIV_W);
            state_in    = ST_WAIT_SL;
         end
         ST_WAIT_SL: begin
            if (div_done) begin
               if (c_ff[FIT_W-1]) begin
                  slope_in = (div_q >= HALF_Q31) ? 32'sh8000_0000
                                                 : -$signed(div_q[Q_W-1:0]);
               end else begin
                  slope_in = (div_q >= HALF_Q31) ? 32'sh7fff_ffff
                                                 : $signed(div_q[Q_W-1:0]);
               end
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            sq_start = 1'b1;
            sq_value = {{(DIV_W-FIT_W){1'b0}}, dx_ff};
            state_in = ST_WAIT_SQX;
         end
         ST_WAIT_SQX: begin
            if (sq_done) begin
               rx_in    = sq_root;
               ax_in    = sq_shift;
               state_in = ST_SQ_Y;
            end
         end
         ST_SQ_Y: begin
            sq_start = 1'b1;
            sq_value = {{(DIV_W-FIT_W){1'b0}}, dy_ff};
            state_in = ST_WAIT_SQY;
         end
         ST_WAIT_SQY: begin
            if (sq_done) begin
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: state_in = ST_DIV_R;
         ST_DIV_R: begin
            div_start        = 1'b1;
            div_req.init_rem = {{(DIV_W-FIT_W){1'b0}}, abs_c};
            div_req.den      = {{(DIV_W-2*ROOT_W){1'b0}}, p_ff};
            div_req.steps    = STEP_W'({1'b0, ax_ff} + {1'b0, sq_shift}) + STEP_W'(16);
            div_req.clamp    = 1'b1;
            state_in         = ST_WAIT_R;
         end
         ST_WAIT_R: begin
            if (div_done) begin
               qq = (div_q + DIV_W'(1)) >> 1;
               if (c_ff[FIT_W-1]) begin
                  corr_in = (qq >= HALF_R) ? 16'sh8000 : -$signed(qq[CORR_W-1:0]);
               end else begin
                  corr_in = (qq >= HALF_R) ? 16'sh7fff : $signed(qq[CORR_W-1:0]);
               end
               idx_in   = '0;
               state_in = ST_O_ADDR;
            end
         end
         ST_O_ADDR: state_in = ST_O_DIFF;
         ST_O_DIFF: begin
            diff_in  = {{2{mem_rdata.x_value[SAMPLE_BITS-1]}}, mem_rdata.x_value, 8'b0}
                     - mean_x_ff[25:0];
            yq_in    = {mem_rdata.y_value, 8'b0};
            state_in = ST_O_MUL;
         end
         ST_O_MUL: state_in = ST_O_EMIT;
         ST_O_EMIT: begin
            strobe_in          = 1'b1;
            rsp_in.point_index = idx_ff;
            rsp_in.predicted_y = pred;
            rsp_in.residual    = sat34(res_sum);
            rsp_in.slope       = slope_ff;
            rsp_in.mean_x      = mean_x_ff;
            rsp_in.mean_y      = mean_y_ff;
            rsp_in.correlation = corr_ff;
            rsp_in.degenerate  = degen_ff;
            rsp_in.last_result = ({1'b0, idx_ff} == count_ff - CNT_W'(1));
            if ({1'b0, idx_ff} == count_ff - CNT_W'(1)) begin
               count_in  = '0;
               sum_x_in  = '0;
               sum_y_in  = '0;
               sum_xx_in = '0;
               sum_yy_in = '0;
               sum_xy_in = '0;
               state_in  = ST_IDLE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_O_ADDR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xx_ff <= '0;
         sum_yy_ff <= '0;
         sum_xy_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xx_ff <= sum_xx_in;
         sum_yy_ff <= sum_yy_in;
         sum_xy_ff <= sum_xy_in;
         strobe_ff <= strobe_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      last_ff   <= last_in;
      prod_ff   <= mul_a * mul_b;
      c_ff      <= c_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      mean_x_ff <= mean_x_in;
      mean_y_ff <= mean_y_in;
      slope_ff  <= slope_in;
      corr_ff   <= corr_in;
      degen_ff  <= degen_in;
      rx_ff     <= rx_in;
      ax_ff     <= ax_in;
      p_ff      <= rx_ff * sq_root;
      idx_ff    <= idx_in;
      diff_ff   <= diff_in;
      yq_ff     <= yq_in;
      pp_ff     <= slope_ff * diff_ff;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/lrf_store.sv
// ----------------------------------------------------------------------------
// lrf_store
// Pair memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_store (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [lrf_pkg::ADDR_W-1:0] wr_addr,
   input  lrf_pkg::pair_type        wr_data,
   input  wire [lrf_pkg::ADDR_W-1:0] rd_addr,
   output lrf_pkg::pair_type        rd_data
);
   import lrf_pkg::*;

   pair_type mem [MAX_PAIRS];
   pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/lrf_divider.sv
// ----------------------------------------------------------------------------
// lrf_divider
// Restoring divider, one quotient bit per cycle, with optional clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_divider (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  lrf_pkg::div_req_type     req,
   output logic                     done,
   output logic [lrf_pkg::DIV_W-1:0] quotient
);
   import lrf_pkg::*;

   localparam logic [DIV_W-1:0] CLAMP_MAX = DIV_W'(1) << 40;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  num_ff, num_in;
   logic [DIV_W-1:0]  den_ff, den_in;
   logic [DIV_W-1:0]  q_ff, q_in;
   logic              clamp_ff, clamp_in;
   logic [DIV_W:0]    rem_sh;
   logic [DIV_W-1:0]  q_sh;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      clamp_in = clamp_ff;
      rem_sh   = {rem_ff, num_ff[DIV_W-1]};
      q_sh     = {q_ff[DIV_W-2:0], 1'b0};
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = req.steps;
         rem_in   = req.init_rem;
         num_in   = req.num;
         den_in   = req.den;
         q_in     = '0;
         clamp_in = req.clamp;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DIV_W'(rem_sh - {1'b0, den_ff});
            q_sh   = q_sh | DIV_W'(1);
         end else begin
            rem_in = rem_sh[DIV_W-1:0];
         end
         if (clamp_ff && (q_sh > CLAMP_MAX)) begin
            q_sh = CLAMP_MAX;
         end
         q_in   = q_sh;
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      q_ff     <= q_in;
      clamp_ff <= clamp_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: hdl/lrf_sqrt.sv
// ----------------------------------------------------------------------------
// lrf_sqrt
// Normalize by powers of four to at least 2^60, then bitwise floor root.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_sqrt (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire [lrf_pkg::DIV_W-1:0]   value,
   output logic                       done,
   output logic [lrf_pkg::ROOT_W-1:0] root,
   output logic [lrf_pkg::SHF_W-1:0]  shift
);
   import lrf_pkg::*;

   localparam logic [DIV_W-1:0] NORM_MIN = DIV_W'(1) << 60;

   sq_state_type      state_ff, state_in;
   logic              done_ff, done_in;
   logic [DIV_W-1:0]  v_ff, v_in;
   logic [DIV_W-1:0]  res_ff, res_in;
   logic [DIV_W-1:0]  bit_ff, bit_in;
   logic [SHF_W-1:0]  a_ff, a_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [DIV_W-1:0]  trial;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      v_in     = v_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      a_in     = a_ff;
      root_in  = root_ff;
      trial    = res_ff + bit_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               v_in     = value;
               a_in     = '0;
               state_in = SQ_NORM;
            end
         end
         SQ_NORM: begin
            if (v_ff < NORM_MIN) begin
               v_in = {v_ff[DIV_W-3:0], 2'b00};
               a_in = a_ff + SHF_W'(1);
            end else begin
               res_in   = '0;
               bit_in   = NORM_MIN;
               state_in = SQ_ROOT;
            end
         end
         SQ_ROOT: begin
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == DIV_W'(1)) begin
               root_in  = res_in[ROOT_W-1:0];
               done_in  = 1'b1;
               state_in = SQ_IDLE;
            end
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      v_ff    <= v_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      a_ff    <= a_in;
      root_ff <= root_in;
   end

   assign done  = done_ff;
   assign root  = root_ff;
   assign shift = a_ff;

endmodule

`default_nettype wire

// File: hdl/lrf_checker.sv
// ----------------------------------------------------------------------------
// lrf_checker
// Port-level checks on result cadence and degenerate results.
// ----------------------------------------------------------------------------
`default_nettype none

module lrf_checker (
   input wire              clock,
   input wire              reset,
   input wire              busy,
   input wire              rsp_strobe,
   input lrf_pkg::rsp_type rsp_data
);
   import lrf_pkg::*;

   a_busy_mid_set: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |-> busy)
      else $error("busy low between results of one set");

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.degenerate |->
         (rsp_data.slope == 0) && (rsp_data.correlation == 0))
      else $error("degenerate result with nonzero slope or correlation");

   a_next_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |-> ##4
         (rsp_strobe && (rsp_data.point_index == IDX_W'($past(rsp_data.point_index, 4)
                                                        + IDX_W'(1)))))
      else $error("next result missing or out of order");

endmodule

bind linear_regression_fit_residuals lrf_checker u_lrf_checker (.*);

`default_nettype wire
